>>> src/lavm_pkg.sv
// ----------------------------------------------------------------------------
// lavm_pkg
// Types and constants shared by the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lavm_pkg;

    localparam int COORD_W  = 32;  // Q16.16 coordinate
    localparam int VEC_W    = 35;  // signed width of any vector fed to the unit stage
    localparam int UNIT_W   = 18;  // signed Q2.16 unit component, |x| <= 1.0
    localparam int FRAC_W   = 16;
    localparam int NORM_BIT = 29;  // block scaling puts the largest magnitude in [2^29, 2^30)
    localparam int PROD_W   = UNIT_W + COORD_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int FX_ONE   = 65536;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef coord_t [2:0] coord_vec_t;
    typedef logic signed [UNIT_W-1:0] unit_t;
    typedef unit_t [2:0] unit_vec_t;

    typedef enum logic [1:0] {
        ROW_RIGHT = 2'd0,
        ROW_UP    = 2'd1,
        ROW_BACK  = 2'd2,
        ROW_HOMOG = 2'd3
    } row_sel_t;

    typedef struct packed {
        coord_t c0;
        coord_t c1;
        coord_t c2;
        coord_t c3;
    } row_vals_t;

    typedef struct packed {
        coord_t cam_x;
        coord_t cam_y;
        coord_t cam_z;
        coord_t target_x;
        coord_t target_y;
        coord_t target_z;
    } in_item_t;

    typedef struct packed {
        logic [1:0] row_index;
        coord_t     entry_c0;
        coord_t     entry_c1;
        coord_t     entry_c2;
        coord_t     entry_c3;
        logic       is_last;
        logic       degenerate;
    } out_item_t;

endpackage

>>> src/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Fixed-point look-at view matrix: camera position and target in, four
// matrix rows (right, up, back, homogeneous) out, one row per transaction.
// ----------------------------------------------------------------------------
//   channel | signals                      | payload
//   --------+------------------------------+----------------------------------
//   input   | in_valid / in_ready          | in_data  (camera, target)
//   output  | out_valid / out_ready        | out_data (one matrix row)
//
// Sustained rate is one input transaction per four output rows, set by the
// row serializer that sends four rows per matrix and stalls on out_ready.
// Each input passes the gaze stage, two normalizer pipelines of 56 stages (31
// root stages, 18 divide stages) in series, and the cross product and
// translation stages. The pipeline only freezes while a finished matrix sits
// in its last stage waiting for the serializer. Reset clears the valid bits.
// ----------------------------------------------------------------------------
module look_at_view_matrix (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lavm_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lavm_pkg::out_item_t  out_data
);

    localparam int VEC_W   = lavm_pkg::VEC_W;
    localparam int UNIT_W  = lavm_pkg::UNIT_W;
    localparam int COORD_W = lavm_pkg::COORD_W;
    localparam int PROD_W  = lavm_pkg::PROD_W;
    localparam int ACC_W   = lavm_pkg::ACC_W;
    localparam int FRAC_W  = lavm_pkg::FRAC_W;
    localparam int POS_W   = 3 * COORD_W;
    localparam int UVEC_W  = 3 * UNIT_W;
    localparam int C_SIDE_W = 2 * UVEC_W + POS_W + 1;

    localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) << (FRAC_W - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI   = (ACC_W'(1) << (COORD_W - 1)) - 1'b1;
    localparam logic signed [ACC_W-1:0] SAT_LO   = -SAT_HI - 1'b1;

    logic en;
    logic ser_load;
    logic t6_valid_reg;

    assign en       = !t6_valid_reg || ser_load;
    assign in_ready = en;

    // ---- gaze difference ----
    lavm_pkg::coord_vec_t pos_in, tgt_in;
    logic [2:0][VEC_W-1:0] d_next;
    logic                  t1_valid_reg;
    logic [2:0][VEC_W-1:0] t1_d_reg;
    logic [2:0][VEC_W-1:0] t1_rv_reg;
    lavm_pkg::coord_vec_t  t1_pos_reg;
    logic                  t1_degen_reg;

    always_comb
    begin
        pos_in = {in_data.cam_z, in_data.cam_y, in_data.cam_x};
        tgt_in = {in_data.target_z, in_data.target_y, in_data.target_x};
        for (int i = 0; i < 3; i++)
        begin
            d_next[i] = VEC_W'($signed(tgt_in[i])) - VEC_W'($signed(pos_in[i]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            t1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_d_reg     <= d_next;
            t1_rv_reg[0] <= '0 - d_next[2];
            t1_rv_reg[1] <= '0;
            t1_rv_reg[2] <= d_next[0];
            t1_pos_reg   <= pos_in;
            t1_degen_reg <= (d_next[0] == '0) && (d_next[2] == '0);
        end
    end

    // ---- dir and right, normalized side by side ----
    logic                 a_valid, b_valid;
    lavm_pkg::unit_vec_t  dir_u, right_u;
    logic [POS_W-1:0]     a_side;
    logic                 b_side;

    lavm_unit3 #(
        .IN_W   (VEC_W),
        .SIDE_W (POS_W)
    ) u_dir (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (t1_valid_reg),
        .vec       (t1_d_reg),
        .side_in   (t1_pos_reg),
        .out_valid (a_valid),
        .unit      (dir_u),
        .side_out  (a_side)
    );

    lavm_unit3 #(
        .IN_W   (VEC_W),
        .SIDE_W (1)
    ) u_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (t1_valid_reg),
        .vec       (t1_rv_reg),
        .side_in   (t1_degen_reg),
        .out_valid (b_valid),
        .unit      (right_u),
        .side_out  (b_side)
    );

    // ---- right x dir: products, then differences ----
    logic                           t2_valid_reg;
    logic signed [2*UNIT_W-1:0]     t2_prod_reg [6];
    lavm_pkg::unit_vec_t            t2_right_reg, t2_dir_reg;
    logic [POS_W-1:0]               t2_pos_reg;
    logic                           t2_degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            t2_valid_reg <= a_valid && b_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t2_prod_reg[0] <= $signed(right_u[1]) * $signed(dir_u[2]);
            t2_prod_reg[1] <= $signed(dir_u[1]) * $signed(right_u[2]);
            t2_prod_reg[2] <= $signed(right_u[2]) * $signed(dir_u[0]);
            t2_prod_reg[3] <= $signed(dir_u[2]) * $signed(right_u[0]);
            t2_prod_reg[4] <= $signed(right_u[0]) * $signed(dir_u[1]);
            t2_prod_reg[5] <= $signed(dir_u[0]) * $signed(right_u[1]);
            t2_right_reg   <= right_u;
            t2_dir_reg     <= dir_u;
            t2_pos_reg     <= a_side;
            t2_degen_reg   <= b_side;
        end
    end

    logic                  t3_valid_reg;
    logic [2:0][VEC_W-1:0] t3_uv_reg;
    logic [C_SIDE_W-1:0]   t3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            t3_valid_reg <= t2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t3_uv_reg[i] <= VEC_W'(t2_prod_reg[2*i]) - VEC_W'(t2_prod_reg[2*i+1]);
            end
            t3_side_reg <= {t2_right_reg, t2_dir_reg, t2_pos_reg, t2_degen_reg};
        end
    end

    // ---- up ----
    logic                 c_valid;
    lavm_pkg::unit_vec_t  up_u;
    logic [C_SIDE_W-1:0]  c_side;

    lavm_unit3 #(
        .IN_W   (VEC_W),
        .SIDE_W (C_SIDE_W)
    ) u_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (t3_valid_reg),
        .vec       (t3_uv_reg),
        .side_in   (t3_side_reg),
        .out_valid (c_valid),
        .unit      (up_u),
        .side_out  (c_side)
    );

    // ---- translation: row . cam ----
    lavm_pkg::unit_vec_t  c_right, c_dir;
    lavm_pkg::coord_vec_t c_pos;
    logic                 c_degen;
    lavm_pkg::unit_vec_t  rows_next [3];

    always_comb
    begin
        {c_right, c_dir, c_pos, c_degen} = c_side;
        rows_next[0] = c_right;
        rows_next[1] = up_u;
        for (int i = 0; i < 3; i++)
        begin
            rows_next[2][i] = '0 - c_dir[i];
        end
    end

    logic                       t4_valid_reg;
    logic signed [PROD_W-1:0]   t4_prod_reg [3][3];
    lavm_pkg::unit_vec_t        t4_rows_reg [3];
    logic                       t4_degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            t4_valid_reg <= c_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    t4_prod_reg[r][c] <= $signed(rows_next[r][c]) * $signed(c_pos[c]);
                end
                t4_rows_reg[r] <= rows_next[r];
            end
            t4_degen_reg <= c_degen;
        end
    end

    // -(sum) + half LSB, floored by the shift in the next stage
    logic                       t5_valid_reg;
    logic signed [ACC_W-1:0]    t5_acc_reg [3];
    lavm_pkg::unit_vec_t        t5_rows_reg [3];
    logic                       t5_degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            t5_valid_reg <= t4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                t5_acc_reg[r] <= RND_BIAS - (ACC_W'(t4_prod_reg[r][0])
                               + ACC_W'(t4_prod_reg[r][1]) + ACC_W'(t4_prod_reg[r][2]));
                t5_rows_reg[r] <= t4_rows_reg[r];
            end
            t5_degen_reg <= t4_degen_reg;
        end
    end

    // round, saturate, and zero everything for a degenerate gaze
    lavm_pkg::row_vals_t     t6_next [3];
    logic signed [ACC_W-1:0] shifted [3];
    lavm_pkg::row_vals_t     t6_rows_reg [3];
    logic                    t6_degen_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            shifted[r]   = t5_acc_reg[r] >>> FRAC_W;
            t6_next[r].c0 = COORD_W'($signed(t5_rows_reg[r][0]));
            t6_next[r].c1 = COORD_W'($signed(t5_rows_reg[r][1]));
            t6_next[r].c2 = COORD_W'($signed(t5_rows_reg[r][2]));
            if (shifted[r] > SAT_HI)
            begin
                t6_next[r].c3 = SAT_HI[COORD_W-1:0];
            end
            else if (shifted[r] < SAT_LO)
            begin
                t6_next[r].c3 = SAT_LO[COORD_W-1:0];
            end
            else
            begin
                t6_next[r].c3 = shifted[r][COORD_W-1:0];
            end
            if (t5_degen_reg)
            begin
                t6_next[r] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            t6_valid_reg <= t5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t6_rows_reg  <= t6_next;
            t6_degen_reg <= t5_degen_reg;
        end
    end

    // ---- row serializer ----
    logic                busy_reg, busy_next;
    lavm_pkg::row_sel_t  row_cnt_reg, row_cnt_next;
    lavm_pkg::row_vals_t hold_rows_reg [3];
    logic                hold_degen_reg;
    logic                out_fire;
    lavm_pkg::row_vals_t vals;

    assign out_fire = busy_reg && out_ready;
    assign ser_load = !busy_reg || (out_ready && row_cnt_reg == lavm_pkg::ROW_HOMOG);

    always_comb
    begin
        busy_next    = ser_load ? t6_valid_reg : busy_reg;
        row_cnt_next = row_cnt_reg;
        if (ser_load)
        begin
            row_cnt_next = lavm_pkg::ROW_RIGHT;
        end
        else if (out_fire)
        begin
            row_cnt_next = lavm_pkg::row_sel_t'(row_cnt_reg + 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            row_cnt_reg <= lavm_pkg::ROW_RIGHT;
        end
        else
        begin
            busy_reg    <= busy_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_load && t6_valid_reg)
        begin
            hold_rows_reg  <= t6_rows_reg;
            hold_degen_reg <= t6_degen_reg;
        end
    end

    always_comb
    begin
        case (row_cnt_reg)
            lavm_pkg::ROW_RIGHT: vals = hold_rows_reg[0];
            lavm_pkg::ROW_UP:    vals = hold_rows_reg[1];
            lavm_pkg::ROW_BACK:  vals = hold_rows_reg[2];
            lavm_pkg::ROW_HOMOG:
            begin
                vals    = '0;
                vals.c3 = hold_degen_reg ? '0 : COORD_W'(lavm_pkg::FX_ONE);
            end
            default:             vals = '0;
        endcase
    end

    assign out_valid           = busy_reg;
    assign out_data.row_index  = row_cnt_reg;
    assign out_data.entry_c0   = vals.c0;
    assign out_data.entry_c1   = vals.c1;
    assign out_data.entry_c2   = vals.c2;
    assign out_data.entry_c3   = vals.c3;
    assign out_data.is_last    = (row_cnt_reg == lavm_pkg::ROW_HOMOG);
    assign out_data.degenerate = hold_degen_reg;

endmodule

>>> src/lavm_unit3.sv
// ----------------------------------------------------------------------------
// lavm_unit3
// Pipelined 3-vector normalizer: block scaling, sum of squares, bit-serial
// square root (one result bit per stage) and restoring division (one
// quotient bit per stage, three lanes). Sideband data rides along.
// ----------------------------------------------------------------------------
module lavm_unit3 #(
    parameter int IN_W   = lavm_pkg::VEC_W,
    parameter int SIDE_W = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [2:0][IN_W-1:0]   vec,
    input  logic [SIDE_W-1:0]      side_in,
    output logic                   out_valid,
    output lavm_pkg::unit_vec_t    unit,
    output logic [SIDE_W-1:0]      side_out
);

    localparam int NORM     = lavm_pkg::NORM_BIT;
    localparam int FRAC     = lavm_pkg::FRAC_W;
    localparam int SC_W     = NORM + 1;
    localparam int SUM_W    = 2 * SC_W + 2;
    localparam int SQ_STEPS = SC_W + 1;
    localparam int MAG_W    = SC_W + 1;
    localparam int Q_W      = lavm_pkg::UNIT_W;
    localparam int NUM_W    = SC_W + FRAC + 1;
    localparam int DEN_W    = MAG_W + Q_W - 1;
    localparam int P_W      = $clog2(IN_W);

    typedef struct packed {
        logic [SUM_W-1:0]         rem;
        logic [SUM_W-1:0]         root;
        logic [2:0][SC_W-1:0]     sc;
        logic [2:0]               neg;
        logic                     zero;
        logic [SIDE_W-1:0]        side;
    } sq_t;

    typedef struct packed {
        logic [2:0][NUM_W-1:0]    rem;
        logic [2:0][Q_W-1:0]      quo;
        logic [MAG_W-1:0]         mag;
        logic [2:0]               neg;
        logic                     zero;
        logic [SIDE_W-1:0]        side;
    } dv_t;

    // stage 1: magnitudes and largest magnitude
    logic [2:0][IN_W-1:0] abs_next;
    logic [IN_W-1:0]      max_next;
    logic                 s1_valid_reg;
    logic [2:0][IN_W-1:0] s1_abs_reg;
    logic [2:0]           s1_neg_reg;
    logic [IN_W-1:0]      s1_max_reg;
    logic [SIDE_W-1:0]    s1_side_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            abs_next[i] = vec[i][IN_W-1] ? (~vec[i] + 1'b1) : vec[i];
        end
        max_next = abs_next[0];
        if (abs_next[1] > max_next)
        begin
            max_next = abs_next[1];
        end
        if (abs_next[2] > max_next)
        begin
            max_next = abs_next[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_abs_reg  <= abs_next;
            s1_neg_reg  <= {vec[2][IN_W-1], vec[1][IN_W-1], vec[0][IN_W-1]};
            s1_max_reg  <= max_next;
            s1_side_reg <= side_in;
        end
    end

    // stage 2: leading one of the largest magnitude
    logic [P_W-1:0]       pos_next;
    logic                 s2_valid_reg;
    logic [2:0][IN_W-1:0] s2_abs_reg;
    logic [2:0]           s2_neg_reg;
    logic [P_W-1:0]       s2_pos_reg;
    logic                 s2_zero_reg;
    logic [SIDE_W-1:0]    s2_side_reg;

    always_comb
    begin
        pos_next = '0;
        for (int b = 0; b < IN_W; b++)
        begin
            if (s1_max_reg[b])
            begin
                pos_next = P_W'(b);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_abs_reg  <= s1_abs_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_pos_reg  <= pos_next;
            s2_zero_reg <= (s1_max_reg == '0);
            s2_side_reg <= s1_side_reg;
        end
    end

    // stage 3: scale so the leading one of the largest lands on bit NORM;
    // right shifts truncate, left shifts are exact
    logic [2:0][SC_W-1:0]     sc_next;
    logic [IN_W+NORM-1:0]     wide;
    logic                     s3_valid_reg;
    logic [2:0][SC_W-1:0]     s3_sc_reg;
    logic [2:0]               s3_neg_reg;
    logic                     s3_zero_reg;
    logic [SIDE_W-1:0]        s3_side_reg;

    always_comb
    begin
        wide = '0;
        for (int i = 0; i < 3; i++)
        begin
            wide       = {s2_abs_reg[i], {NORM{1'b0}}} >> s2_pos_reg;
            sc_next[i] = wide[SC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_sc_reg   <= sc_next;
            s3_neg_reg  <= s2_neg_reg;
            s3_zero_reg <= s2_zero_reg;
            s3_side_reg <= s2_side_reg;
        end
    end

    // stage 4: squares
    logic                       s4_valid_reg;
    logic [2:0][2*SC_W-1:0]     s4_sq_reg;
    logic [2:0][SC_W-1:0]       s4_sc_reg;
    logic [2:0]                 s4_neg_reg;
    logic                       s4_zero_reg;
    logic [SIDE_W-1:0]          s4_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s4_sq_reg[i] <= s3_sc_reg[i] * s3_sc_reg[i];
            end
            s4_sc_reg   <= s3_sc_reg;
            s4_neg_reg  <= s3_neg_reg;
            s4_zero_reg <= s3_zero_reg;
            s4_side_reg <= s3_side_reg;
        end
    end

    // stage 5: sum of squares, seeds the root pipeline
    sq_t  sq_reg [SQ_STEPS+1];
    logic sq_valid_reg [SQ_STEPS+1];
    sq_t  sq0_next;

    always_comb
    begin
        sq0_next.rem  = SUM_W'(s4_sq_reg[0]) + SUM_W'(s4_sq_reg[1]) + SUM_W'(s4_sq_reg[2]);
        sq0_next.root = '0;
        sq0_next.sc   = s4_sc_reg;
        sq0_next.neg  = s4_neg_reg;
        sq0_next.zero = s4_zero_reg;
        sq0_next.side = s4_side_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sq_valid_reg[0] <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg[0] <= sq0_next;
        end
    end

    // floor square root, one result bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        localparam logic [SUM_W-1:0] STEP_BIT = SUM_W'(1) << (2 * (SQ_STEPS - 1 - k));
        logic [SUM_W:0] trial;
        sq_t            step_next;

        always_comb
        begin
            step_next = sq_reg[k];
            trial     = {1'b0, sq_reg[k].root} + {1'b0, STEP_BIT};
            if ({1'b0, sq_reg[k].rem} >= trial)
            begin
                step_next.rem  = sq_reg[k].rem - trial[SUM_W-1:0];
                step_next.root = (sq_reg[k].root >> 1) + STEP_BIT;
            end
            else
            begin
                step_next.root = sq_reg[k].root >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[k+1] <= step_next;
            end
        end
    end

    // numerators a*2^16 + mag/2 for the three lanes
    dv_t              dv_reg [Q_W+1];
    logic             dv_valid_reg [Q_W+1];
    dv_t              dv0_next;
    logic [MAG_W-1:0] mag;

    always_comb
    begin
        mag           = sq_reg[SQ_STEPS].root[MAG_W-1:0];
        dv0_next.mag  = mag;
        dv0_next.quo  = '0;
        dv0_next.neg  = sq_reg[SQ_STEPS].neg;
        dv0_next.zero = sq_reg[SQ_STEPS].zero;
        dv0_next.side = sq_reg[SQ_STEPS].side;
        for (int i = 0; i < 3; i++)
        begin
            dv0_next.rem[i] = NUM_W'({sq_reg[SQ_STEPS].sc[i], {FRAC{1'b0}}})
                            + NUM_W'(mag >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_valid_reg[0] <= sq_valid_reg[SQ_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg[0] <= dv0_next;
        end
    end

    // restoring division, MSB of the quotient first
    for (genvar j = 0; j < Q_W; j++)
    begin : g_div
        localparam int QB = Q_W - 1 - j;
        logic [DEN_W-1:0] den;
        dv_t              step_next;

        always_comb
        begin
            step_next = dv_reg[j];
            den       = DEN_W'(dv_reg[j].mag) << QB;
            for (int i = 0; i < 3; i++)
            begin
                if (DEN_W'(dv_reg[j].rem[i]) >= den)
                begin
                    step_next.rem[i]     = NUM_W'(DEN_W'(dv_reg[j].rem[i]) - den);
                    step_next.quo[i][QB] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[j+1] <= step_next;
            end
        end
    end

    // sign back on, zero vector gives zero
    lavm_pkg::unit_vec_t unit_next;
    logic                out_valid_reg;
    lavm_pkg::unit_vec_t unit_reg;
    logic [SIDE_W-1:0]   side_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_reg[Q_W].zero)
            begin
                unit_next[i] = '0;
            end
            else if (dv_reg[Q_W].neg[i])
            begin
                unit_next[i] = ~dv_reg[Q_W].quo[i] + 1'b1;
            end
            else
            begin
                unit_next[i] = dv_reg[Q_W].quo[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid_reg[Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unit_reg <= unit_next;
            side_reg <= dv_reg[Q_W].side;
        end
    end

    assign out_valid = out_valid_reg;
    assign unit      = unit_reg;
    assign side_out  = side_reg;

endmodule

>>> bench/look_at_view_matrix_tb.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix_tb
// Drives camera/target pairs through the look-at pipeline with random gaps
// and output stalls, predicts the four matrix rows of each transaction in
// fixed point and compares every received row field by field.
// ----------------------------------------------------------------------------
module look_at_view_matrix_tb;

    typedef longint signed s64_t;
    typedef s64_t vec3_t [3];

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    lavm_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_ready;
    lavm_pkg::out_item_t out_data;

    lavm_pkg::in_item_t  pending_items[$];
    lavm_pkg::out_item_t expected_rows[$];
    int        mismatches;
    int        rows_seen;
    int        degen_seen;
    int        cycle_count;
    bit        stim_done;
    int        send_wait;
    int        recv_wait;
    bit        in_taken;
    bit        out_taken;

    localparam int CYCLE_LIMIT = 600000;

    look_at_view_matrix DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic s64_t int_sqrt(s64_t val);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = val;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return s64_t'(r);
    endfunction

    function automatic vec3_t normalize(vec3_t v);
        vec3_t u;
        logic [63:0] a [3];
        logic [63:0] m;
        logic [63:0] sum;
        logic [63:0] mag;
        logic [63:0] q;
        m = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = (v[i] < 0) ? -v[i] : v[i];
            if (a[i] > m)
                m = a[i];
        end
        if (m == 0)
        begin
            u[0] = 0; u[1] = 0; u[2] = 0;
            return u;
        end
        while (m >= (64'd1 << 30))
        begin
            m = m >> 1;
            for (int i = 0; i < 3; i++)
                a[i] = a[i] >> 1;
        end
        while (m < (64'd1 << 29))
        begin
            m = m << 1;
            for (int i = 0; i < 3; i++)
                a[i] = a[i] << 1;
        end
        for (int i = 0; i < 3; i++)
            sum = sum + a[i] * a[i];
        mag = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((a[i] << 16) + (mag >> 1)) / mag;
            u[i] = (v[i] < 0) ? -s64_t'(q) : s64_t'(q);
        end
        return u;
    endfunction

    // -(row . cam) in Q32.32, rounded half up to Q16.16, saturated
    function automatic lavm_pkg::coord_t translation(vec3_t r, vec3_t p);
        s64_t t;
        s64_t rnd;
        t = -(r[0] * p[0] + r[1] * p[1] + r[2] * p[2]) + 32768;
        rnd = t >>> 16;
        if (rnd > 64'sd2147483647)
            rnd = 64'sd2147483647;
        if (rnd < -64'sd2147483648)
            rnd = -64'sd2147483648;
        return lavm_pkg::coord_t'(rnd);
    endfunction

    task automatic predict_matrix(lavm_pkg::in_item_t it);
        vec3_t pos;
        vec3_t d;
        vec3_t dir;
        vec3_t rv;
        vec3_t rgt;
        vec3_t cr;
        vec3_t upv;
        vec3_t back;
        lavm_pkg::out_item_t row;
        bit degen;
        pos[0] = it.cam_x; pos[1] = it.cam_y; pos[2] = it.cam_z;
        d[0] = s64_t'(it.target_x) - pos[0];
        d[1] = s64_t'(it.target_y) - pos[1];
        d[2] = s64_t'(it.target_z) - pos[2];
        degen = (d[0] == 0 && d[2] == 0);
        dir = normalize(d);
        rv[0] = -d[2]; rv[1] = 0; rv[2] = d[0];
        rgt = normalize(rv);
        cr[0] = rgt[1] * dir[2] - dir[1] * rgt[2];
        cr[1] = rgt[2] * dir[0] - dir[2] * rgt[0];
        cr[2] = rgt[0] * dir[1] - dir[0] * rgt[1];
        upv = normalize(cr);
        for (int i = 0; i < 3; i++)
            back[i] = -dir[i];
        for (int k = 0; k < 4; k++)
        begin
            row = '0;
            row.row_index = 2'(k);
            row.is_last = (k == lavm_pkg::ROW_HOMOG);
            row.degenerate = degen;
            if (!degen)
            begin
                case (lavm_pkg::row_sel_t'(k))
                    lavm_pkg::ROW_RIGHT:
                    begin
                        row.entry_c0 = rgt[0]; row.entry_c1 = rgt[1];
                        row.entry_c2 = rgt[2]; row.entry_c3 = translation(rgt, pos);
                    end
                    lavm_pkg::ROW_UP:
                    begin
                        row.entry_c0 = upv[0]; row.entry_c1 = upv[1];
                        row.entry_c2 = upv[2]; row.entry_c3 = translation(upv, pos);
                    end
                    lavm_pkg::ROW_BACK:
                    begin
                        row.entry_c0 = back[0]; row.entry_c1 = back[1];
                        row.entry_c2 = back[2]; row.entry_c3 = translation(back, pos);
                    end
                    default:
                        row.entry_c3 = lavm_pkg::FX_ONE;
                endcase
            end
            expected_rows.push_back(row);
        end
    endtask

    function automatic lavm_pkg::coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return lavm_pkg::coord_t'($urandom);
            1: return lavm_pkg::coord_t'($urandom_range(0, 20) << 16)
                      - lavm_pkg::coord_t'(10 << 16);
            2: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return lavm_pkg::coord_t'(int'($urandom_range(0, 2000000)) - 1000000) << 4;
        endcase
    endfunction

    function automatic lavm_pkg::in_item_t make_item(
        lavm_pkg::coord_t cx, lavm_pkg::coord_t cy, lavm_pkg::coord_t cz,
        lavm_pkg::coord_t tx, lavm_pkg::coord_t ty, lavm_pkg::coord_t tz);
        lavm_pkg::in_item_t it;
        it.cam_x = cx; it.cam_y = cy; it.cam_z = cz;
        it.target_x = tx; it.target_y = ty; it.target_z = tz;
        return it;
    endfunction

    // Driver: one transaction from the pending queue, then its random gap
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            send_wait <= 0;
        end
        else if (in_valid && !in_taken)
            ; // hold until accepted
        else if (send_wait > 0)
        begin
            in_valid <= 1'b0;
            send_wait <= send_wait - 1;
        end
        else if (pending_items.size() > 0)
        begin
            send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            in_valid <= 1'b1;
            in_data <= pending_items.pop_front();
        end
        else
            in_valid <= 1'b0;
    end

    // Driver accept bookkeeping: the item in flight is predicted on accept
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            predict_matrix(in_data);
    end

    // Output stalls, drawn after every received row
    always @(negedge clk or negedge rst_n)
    begin : recv_side
        int gap;
        gap = 0;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait <= 0;
        end
        else if (recv_wait > 0)
        begin
            out_ready <= 1'b0;
            recv_wait <= recv_wait - 1;
        end
        else if (out_taken)
        begin
            gap = $urandom_range(0, 14);
            out_ready <= (gap == 0);
            recv_wait <= (gap > 0) ? gap - 1 : 0;
        end
        else
            out_ready <= 1'b1;
    end

    // Monitor
    always @(posedge clk)
    begin
        out_taken <= rst_n && out_valid && out_ready;
        if (rst_n && out_valid && out_ready)
        begin
            rows_seen <= rows_seen + 1;
            if (out_data.degenerate)
                degen_seen <= degen_seen + 1;
            if (expected_rows.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected row transaction: %p", out_data);
            end
            else if (expected_rows[0] !== out_data)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("row mismatch\n  exp %p\n  got %p", expected_rows[0], out_data);
                void'(expected_rows.pop_front());
            end
            else
                void'(expected_rows.pop_front());
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout with %0d rows outstanding", expected_rows.size());
            $display("look_at_view_matrix_tb failed");
            $finish;
        end
    end

    initial
    begin
        lavm_pkg::coord_t cx;
        lavm_pkg::coord_t cy;
        lavm_pkg::coord_t cz;
        mismatches = 0;
        rows_seen = 0;
        degen_seen = 0;
        cycle_count = 0;
        stim_done = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        // Directed: axis gazes, zero and vertical gaze, extremes
        pending_items.push_back(make_item(0, 0, 0, 0, 0, -32'sh10000));
        pending_items.push_back(make_item(0, 0, 0, 32'sh10000, 0, 0));
        pending_items.push_back(make_item(32'sh30000, 32'sh20000, 32'sh50000, 0, 0, 0));
        pending_items.push_back(make_item(5, 6, 7, 5, 6, 7));
        pending_items.push_back(make_item(0, 0, 0, 0, 32'sh10000, 0));
        pending_items.push_back(make_item(0, 32'sh7FFFFFFF, 0, 0, 32'sh80000000, 0));
        pending_items.push_back(make_item(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                          32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
        pending_items.push_back(make_item(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                          32'sh80000000, 32'sh80000000, 32'sh80000000));
        pending_items.push_back(make_item(32'sh7FFFFFFF, 0, 32'sh80000000,
                                          32'sh80000000, 32'sh12345678, 32'sh7FFFFFFF));
        pending_items.push_back(make_item(0, 0, 0, 1, 0, 0));
        pending_items.push_back(make_item(0, 0, 0, 0, 32'sh7FFFFFFF, 1));
        pending_items.push_back(make_item(0, 32'sh80000000, 0, -1, 32'sh7FFFFFFF, -1));
        pending_items.push_back(make_item(32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF,
                                          32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA));
        pending_items.push_back(make_item(32'sh55555555, 32'shAAAAAAAA, 32'sh55555555,
                                          0, 0, 0));
        for (int n = 0; n < 260; n++)
        begin
            cx = rand_coord(); cy = rand_coord(); cz = rand_coord();
            if ($urandom_range(0, 15) == 0)
                pending_items.push_back(make_item(cx, cy, cz, cx, rand_coord(), cz));
            else
                pending_items.push_back(make_item(cx, cy, cz,
                                                  rand_coord(), rand_coord(), rand_coord()));
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (pending_items.size() == 0);
        @(posedge clk);
        while (in_valid)
            @(posedge clk);
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("checked %0d matrix rows (%0d degenerate) under random gaps and stalls",
                 rows_seen, degen_seen);
        if (mismatches == 0 && expected_rows.size() == 0)
            $display("look_at_view_matrix_tb passed");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("look_at_view_matrix_tb failed");
        end
        $finish;
    end
endmodule

>>> look_at_view_matrix.f
src/lavm_pkg.sv
src/lavm_unit3.sv
src/look_at_view_matrix.sv
bench/look_at_view_matrix_tb.sv
